FILE: hw/rtl/fcwd_pkg.sv
// shared constants, codes and command/status types for the fir convolution block
// depends on nothing; used by fcwd_ctrl, fcwd_datapath and the top level by scoped names
`default_nettype none

package fcwd_pkg;

    // storage sizes
    localparam int MAX_TAPS   = 256;
    localparam int CHANNELS   = 2;
    localparam int TAP_W      = $clog2(MAX_TAPS);
    localparam int N_W        = $clog2(MAX_TAPS + 1);
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HIST_DEPTH = CHANNELS * MAX_TAPS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    // field widths
    localparam int OP_W     = 2;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int IDX_W    = 8;
    localparam int TAPCNT_W = 9;
    localparam int LEVEL_W  = 16;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 16;

    // arithmetic widths
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = PROD_W + TAP_W;
    localparam int ACC_LO_W = ACC_W / 2;
    localparam int ACC_HI_W = ACC_W - ACC_LO_W;
    localparam int GAIN_W   = LEVEL_W + 1;
    localparam int MB_W     = ACC_LO_W + 1;
    localparam int MP_W     = GAIN_W + MB_W;
    localparam int TOT_W    = ACC_W + 18;
    localparam int Q_W      = TOT_W - 30;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(32768);

    // stream packing, lowest bits first
    localparam int IN_SAMPLE_LSB = 0;
    localparam int IN_CH_LSB     = IN_SAMPLE_LSB + SAMPLE_W;
    localparam int IN_IDX_LSB    = IN_CH_LSB + 1;
    localparam int IN_COEF_LSB   = IN_IDX_LSB + IDX_W;
    localparam int IN_USED_W     = IN_COEF_LSB + COEF_W;
    localparam int IN_DATA_W     = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_USED_W    = SAMPLE_W + 1;
    localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    // item kinds
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_COEF   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_ENABLED   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_TAP_COUNT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_WET_LEVEL = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_DRY_LEVEL = 2'd3;

    // shared multiplier operand select
    localparam logic [1:0] MUL_HI  = 2'd0;
    localparam logic [1:0] MUL_LO  = 2'd1;
    localparam logic [1:0] MUL_DRY = 2'd2;

    // mix total update
    localparam logic [1:0] TOT_HOLD    = 2'd0;
    localparam logic [1:0] TOT_LOAD_HI = 2'd1;
    localparam logic [1:0] TOT_ADD     = 2'd2;
    localparam logic [1:0] TOT_ADD_DRY = 2'd3;

    typedef struct packed {
        logic       load;
        logic       coef_we;
        logic       clear_start;
        logic       clear_step;
        logic       hist_wr;
        logic       mac_issue;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic [1:0] tot_op;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic filter_on;
        logic clr_last;
        logic mac_last;
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

FILE: hw/rtl/fir_convolution_wet_dry.sv
// top level of the fir convolution with dry/wet mix: stream ports and config port
// depends on fcwd_pkg, fcwd_ctrl and fcwd_datapath
//
// channel   dir   handshake                     contents
// s_axis    in    s_axis_tvalid/s_axis_tready   op in tuser; sample, channel, tap in tdata
// m_axis    out   m_axis_tvalid/m_axis_tready   mixed sample, channel in tdata
// cfg       in    i_cfg_we                      register index and write data
//
// a filtered sample runs the mac loop over n taps, n being tap_count capped at 256,
// at one tap per cycle, then goes through the mix to the output register
// a bypassed sample skips the tap loop and the mix; a coefficient write completes in idle
// after reset and after a clear item the history ram is swept to zero with no input taken
// the output register holds a result while the next transaction is accepted
`default_nettype none

module fir_convolution_wet_dry (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // op
    input  wire logic [fcwd_pkg::OP_W-1:0]          s_axis_tuser,
    // sample[15:0], channel[16], coef_index[24:17], coef_value[40:25], zero pad
    input  wire logic [fcwd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // out_sample[15:0], out_channel[16], zero pad
    output logic      [fcwd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  wire logic                               i_cfg_we,
    input  wire logic [fcwd_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  wire logic [fcwd_pkg::CFG_DW-1:0]        i_cfg_wdata
);

    fcwd_pkg::t_cmd    cmd;
    fcwd_pkg::t_status status;
    logic [fcwd_pkg::SAMPLE_W-1:0] out_sample;
    logic                          out_channel;

    fcwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fcwd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_sample      (s_axis_tdata[fcwd_pkg::IN_SAMPLE_LSB +: fcwd_pkg::SAMPLE_W]),
        .i_channel     (s_axis_tdata[fcwd_pkg::IN_CH_LSB]),
        .i_coef_index  (s_axis_tdata[fcwd_pkg::IN_IDX_LSB +: fcwd_pkg::IDX_W]),
        .i_coef_value  (s_axis_tdata[fcwd_pkg::IN_COEF_LSB +: fcwd_pkg::COEF_W]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_sample  (out_sample),
        .o_out_channel (out_channel)
    );

    assign m_axis_tdata = {{(fcwd_pkg::OUT_DATA_W - fcwd_pkg::OUT_USED_W){1'b0}},
                           out_channel, out_sample};

endmodule

`default_nettype wire

FILE: hw/rtl/fcwd_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// depends on nothing
`default_nettype none

module fcwd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/fcwd_ctrl.sv
// controller state machine: sequences clear sweep, tap loop, mix and output
// depends on fcwd_pkg
`default_nettype none

module fcwd_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic [fcwd_pkg::OP_W-1:0] i_op,
    output logic                          o_in_ready,
    input  wire fcwd_pkg::t_status        i_status,
    output fcwd_pkg::t_cmd                o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_WRITE = 4'd2;
    localparam logic [3:0] S_MAC   = 4'd3;
    localparam logic [3:0] S_DRAIN = 4'd4;
    localparam logic [3:0] S_MIX1  = 4'd5;
    localparam logic [3:0] S_MIX2  = 4'd6;
    localparam logic [3:0] S_MIX3  = 4'd7;
    localparam logic [3:0] S_MIX4  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = fcwd_pkg::MUL_HI;
        o_cmd.tot_op  = fcwd_pkg::TOT_HOLD;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        fcwd_pkg::OP_SAMPLE: begin
                            o_cmd.load = 1'b1;
                            n_state = i_status.filter_on ? S_WRITE : S_FIN;
                        end
                        fcwd_pkg::OP_COEF: begin
                            o_cmd.coef_we = 1'b1;
                        end
                        fcwd_pkg::OP_CLEAR: begin
                            o_cmd.clear_start = 1'b1;
                            n_state = S_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.hist_wr = 1'b1;
                n_state = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac_issue = 1'b1;
                if (i_status.mac_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_MIX1;
                end
            end
            S_MIX1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = fcwd_pkg::MUL_HI;
                n_state = S_MIX2;
            end
            S_MIX2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = fcwd_pkg::MUL_LO;
                o_cmd.tot_op  = fcwd_pkg::TOT_LOAD_HI;
                n_state = S_MIX3;
            end
            S_MIX3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = fcwd_pkg::MUL_DRY;
                o_cmd.tot_op  = fcwd_pkg::TOT_ADD;
                n_state = S_MIX4;
            end
            S_MIX4: begin
                o_cmd.tot_op = fcwd_pkg::TOT_ADD_DRY;
                n_state = S_FIN;
            end
            S_FIN: begin
                // hold the result until the output register can take it
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fcwd_datapath.sv
// datapath: config registers, history and tap rams, mac pipeline, mix and output register
// depends on fcwd_pkg and fcwd_ram
`default_nettype none

module fcwd_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire fcwd_pkg::t_cmd                  i_cmd,
    output fcwd_pkg::t_status                    o_status,
    input  wire logic                            i_cfg_we,
    input  wire logic [fcwd_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  wire logic [fcwd_pkg::CFG_DW-1:0]     i_cfg_wdata,
    input  wire logic [fcwd_pkg::SAMPLE_W-1:0]   i_sample,
    input  wire logic                            i_channel,
    input  wire logic [fcwd_pkg::IDX_W-1:0]      i_coef_index,
    input  wire logic [fcwd_pkg::COEF_W-1:0]     i_coef_value,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [fcwd_pkg::SAMPLE_W-1:0]   o_out_sample,
    output logic                                 o_out_channel
);

    // configuration
    logic                              r_enabled;
    logic [fcwd_pkg::TAPCNT_W-1:0]     r_tap_count;
    logic [fcwd_pkg::LEVEL_W-1:0]      r_wet_level;
    logic [fcwd_pkg::LEVEL_W-1:0]      r_dry_level;

    logic [fcwd_pkg::N_W-1:0]          n_taps;
    logic [fcwd_pkg::LEVEL_W-1:0]      wet;
    logic [fcwd_pkg::LEVEL_W-1:0]      dry;

    // item context
    logic signed [fcwd_pkg::SAMPLE_W-1:0] r_x;
    logic [fcwd_pkg::CH_W-1:0]         r_ch;
    logic                              r_ch_in;
    logic                              r_byp;
    logic [fcwd_pkg::TAP_W-1:0]        r_pos;
    logic [fcwd_pkg::TAP_W-1:0]        r_wpos [fcwd_pkg::CHANNELS];
    logic [fcwd_pkg::CH_W-1:0]         in_ch;
    logic [fcwd_pkg::TAP_W-1:0]        pos_eff;
    logic [fcwd_pkg::N_W-1:0]          pos_inc;

    // tap loop
    logic [fcwd_pkg::N_W-1:0]          r_j;
    logic [fcwd_pkg::TAP_W-1:0]        r_idx;
    logic                              r_rd_vld;
    logic                              r_mul_vld;
    logic signed [fcwd_pkg::PROD_W-1:0] r_prod;
    logic signed [fcwd_pkg::ACC_W-1:0] r_acc;

    // clear sweep
    logic [fcwd_pkg::HIST_AW-1:0]      r_clr;
    logic                              clr_last;

    // rams
    logic                              hist_we;
    logic [fcwd_pkg::HIST_AW-1:0]      hist_waddr;
    logic [fcwd_pkg::SAMPLE_W-1:0]     hist_wdata;
    logic [fcwd_pkg::HIST_AW-1:0]      hist_raddr;
    logic [fcwd_pkg::SAMPLE_W-1:0]     hist_rdata;
    logic                              coef_we;
    logic [fcwd_pkg::COEF_W-1:0]       coef_rdata;

    // mix
    logic signed [fcwd_pkg::GAIN_W-1:0] mul_a;
    logic signed [fcwd_pkg::MB_W-1:0]   mul_b;
    logic signed [fcwd_pkg::MP_W-1:0]   r_mp;
    logic signed [fcwd_pkg::TOT_W-1:0]  r_tot;
    logic signed [fcwd_pkg::TOT_W-1:0]  rnd;
    logic signed [fcwd_pkg::Q_W-1:0]    q;
    logic [fcwd_pkg::SAMPLE_W-1:0]      sat;

    localparam logic signed [fcwd_pkg::Q_W-1:0] Q_MAX = fcwd_pkg::Q_W'(32767);
    localparam logic signed [fcwd_pkg::Q_W-1:0] Q_MIN = fcwd_pkg::Q_W'(-32768);
    localparam logic signed [fcwd_pkg::TOT_W-1:0] RND_HALF = fcwd_pkg::TOT_W'(1) <<< 29;

    // output register
    logic                              r_out_valid;
    logic [fcwd_pkg::SAMPLE_W-1:0]     r_out_sample;
    logic                              r_out_channel;

    assign n_taps = (32'(r_tap_count) > fcwd_pkg::MAX_TAPS) ?
                    fcwd_pkg::N_W'(fcwd_pkg::MAX_TAPS) : fcwd_pkg::N_W'(r_tap_count);
    assign wet = (r_wet_level > fcwd_pkg::LEVEL_ONE) ? fcwd_pkg::LEVEL_ONE : r_wet_level;
    assign dry = (r_dry_level > fcwd_pkg::LEVEL_ONE) ? fcwd_pkg::LEVEL_ONE : r_dry_level;

    // channel taken modulo the channel count for storage
    assign in_ch   = (fcwd_pkg::CHANNELS > 1) ? fcwd_pkg::CH_W'(i_channel) : '0;
    // stale write position restarts at zero
    assign pos_eff = (fcwd_pkg::N_W'(r_wpos[in_ch]) >= n_taps) ? '0 : r_wpos[in_ch];
    assign pos_inc = fcwd_pkg::N_W'(r_pos) + fcwd_pkg::N_W'(1);

    assign clr_last = (r_clr == fcwd_pkg::HIST_AW'(fcwd_pkg::HIST_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b1;
            r_tap_count <= '0;
            r_wet_level <= fcwd_pkg::LEVEL_ONE;
            r_dry_level <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                fcwd_pkg::CFG_ENABLED:   r_enabled   <= i_cfg_wdata[0];
                fcwd_pkg::CFG_TAP_COUNT: r_tap_count <= i_cfg_wdata[fcwd_pkg::TAPCNT_W-1:0];
                fcwd_pkg::CFG_WET_LEVEL: r_wet_level <= i_cfg_wdata[fcwd_pkg::LEVEL_W-1:0];
                fcwd_pkg::CFG_DRY_LEVEL: r_dry_level <= i_cfg_wdata[fcwd_pkg::LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // write positions and clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < fcwd_pkg::CHANNELS; c++) begin
                r_wpos[c] <= '0;
            end
            r_clr <= '0;
        end else begin
            if (i_cmd.clear_start) begin
                for (int c = 0; c < fcwd_pkg::CHANNELS; c++) begin
                    r_wpos[c] <= '0;
                end
                r_clr <= '0;
            end else if (i_cmd.clear_step) begin
                r_clr <= clr_last ? '0 : r_clr + fcwd_pkg::HIST_AW'(1);
            end
            if (i_cmd.hist_wr) begin
                r_wpos[r_ch] <= (pos_inc >= n_taps) ? '0 : r_pos + fcwd_pkg::TAP_W'(1);
            end
        end
    end

    // item context and tap loop counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= i_sample;
            r_ch    <= in_ch;
            r_ch_in <= i_channel;
            r_byp   <= !o_status.filter_on;
            r_pos   <= pos_eff;
            r_idx   <= pos_eff;
            r_j     <= '0;
        end else if (i_cmd.mac_issue) begin
            r_j   <= r_j + fcwd_pkg::N_W'(1);
            // newest sample first, walking back around the circular history
            r_idx <= (r_idx == '0) ? fcwd_pkg::TAP_W'(n_taps - fcwd_pkg::N_W'(1))
                                   : r_idx - fcwd_pkg::TAP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_mul_vld <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.mac_issue;
            r_mul_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_prod <= $signed(hist_rdata) * $signed(coef_rdata);
        end
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + fcwd_pkg::ACC_W'(r_prod);
        end
    end

    assign hist_we    = i_cmd.clear_step || i_cmd.hist_wr;
    assign hist_waddr = i_cmd.clear_step ? r_clr :
                        fcwd_pkg::HIST_AW'(fcwd_pkg::HIST_AW'(r_ch) *
                        fcwd_pkg::HIST_AW'(fcwd_pkg::MAX_TAPS) + fcwd_pkg::HIST_AW'(r_pos));
    assign hist_wdata = i_cmd.clear_step ? '0 : r_x;
    assign hist_raddr = fcwd_pkg::HIST_AW'(fcwd_pkg::HIST_AW'(r_ch) *
                        fcwd_pkg::HIST_AW'(fcwd_pkg::MAX_TAPS) + fcwd_pkg::HIST_AW'(r_idx));

    assign coef_we = i_cmd.coef_we && (32'(i_coef_index) < fcwd_pkg::MAX_TAPS);

    fcwd_ram #(
        .WIDTH (fcwd_pkg::SAMPLE_W),
        .DEPTH (fcwd_pkg::HIST_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    fcwd_ram #(
        .WIDTH (fcwd_pkg::COEF_W),
        .DEPTH (fcwd_pkg::MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (fcwd_pkg::TAP_W'(i_coef_index)),
        .i_wdata (i_coef_value),
        .i_raddr (r_j[fcwd_pkg::TAP_W-1:0]),
        .o_rdata (coef_rdata)
    );

    // shared multiplier: wet * acc split in two halves, then dry * x
    always_comb begin
        mul_a = (i_cmd.mul_sel == fcwd_pkg::MUL_DRY) ?
                $signed({1'b0, dry}) : $signed({1'b0, wet});
        case (i_cmd.mul_sel)
            fcwd_pkg::MUL_HI:  mul_b = fcwd_pkg::MB_W'($signed(
                                   r_acc[fcwd_pkg::ACC_W-1 -: fcwd_pkg::ACC_HI_W]));
            fcwd_pkg::MUL_LO:  mul_b = $signed({1'b0, r_acc[fcwd_pkg::ACC_LO_W-1:0]});
            fcwd_pkg::MUL_DRY: mul_b = fcwd_pkg::MB_W'(r_x);
            default:           mul_b = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_mp <= mul_a * mul_b;
        end
        case (i_cmd.tot_op)
            fcwd_pkg::TOT_LOAD_HI: r_tot <= fcwd_pkg::TOT_W'(r_mp) <<< fcwd_pkg::ACC_LO_W;
            fcwd_pkg::TOT_ADD:     r_tot <= r_tot + fcwd_pkg::TOT_W'(r_mp);
            fcwd_pkg::TOT_ADD_DRY: r_tot <= r_tot + (fcwd_pkg::TOT_W'(r_mp) <<< 15);
            default: begin
            end
        endcase
    end

    // round half up to q1.15, then saturate
    assign rnd = r_tot + RND_HALF;
    assign q   = rnd[fcwd_pkg::TOT_W-1:30];
    assign sat = (q > Q_MAX) ? 16'h7fff :
                 (q < Q_MIN) ? 16'h8000 : q[fcwd_pkg::SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sample  <= r_byp ? r_x : sat;
            r_out_channel <= r_ch_in;
        end
    end

    assign o_status.filter_on = r_enabled && (n_taps != '0);
    assign o_status.clr_last  = clr_last;
    assign o_status.mac_last  = (r_j == n_taps - fcwd_pkg::N_W'(1));
    assign o_status.pipe_busy = r_rd_vld || r_mul_vld;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_out_sample  = r_out_sample;
    assign o_out_channel = r_out_channel;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// self-checking testbench for fir_convolution_wet_dry: streams samples, taps and clears,
// predicts each mixed output in a scoreboard class and compares it on the master side
// depends on fcwd_pkg and the fir_convolution_wet_dry rtl
`timescale 1ns / 1ps

class fir_mix_scoreboard;
    typedef struct {
        logic signed [fcwd_pkg::SAMPLE_W-1:0] smp;
        logic                                 ch;
    } mix_result_t;

    logic                                 filter_on;
    int unsigned                          taps;
    int unsigned                          wet;
    int unsigned                          dry;
    logic signed [fcwd_pkg::SAMPLE_W-1:0] hist [fcwd_pkg::CHANNELS][fcwd_pkg::MAX_TAPS];
    logic signed [fcwd_pkg::COEF_W-1:0]   coefs [fcwd_pkg::MAX_TAPS];
    int unsigned                          wpos [fcwd_pkg::CHANNELS];
    mix_result_t                          expected_mix [$];
    int                                   mismatches;

    function new();
        filter_on  = 1'b1;
        taps       = 0;
        wet        = 32768;
        dry        = 0;
        mismatches = 0;
        foreach (hist[c, k]) hist[c][k] = '0;
        foreach (coefs[k]) coefs[k] = '0;
        foreach (wpos[c]) wpos[c] = 0;
    endfunction

    function void set_register(logic [fcwd_pkg::CFG_AW-1:0] idx,
                               logic [fcwd_pkg::CFG_DW-1:0] value);
        case (idx)
            fcwd_pkg::CFG_ENABLED:   filter_on = value[0];
            fcwd_pkg::CFG_TAP_COUNT: taps = value[fcwd_pkg::TAPCNT_W-1:0];
            fcwd_pkg::CFG_WET_LEVEL: wet = value;
            fcwd_pkg::CFG_DRY_LEVEL: dry = value;
            default: ;
        endcase
    endfunction

    // convolve, mix, round half up and saturate, advancing the channel's write position; bypass returns x as is
    function logic signed [fcwd_pkg::SAMPLE_W-1:0] mix_sample(
            logic signed [fcwd_pkg::SAMPLE_W-1:0] x, int unsigned ch);
        int unsigned n;
        int unsigned pos;
        int unsigned g_wet;
        int unsigned g_dry;
        int unsigned idx;
        int unsigned j;
        longint      acc;
        longint      total;
        longint      q;
        n = (taps > fcwd_pkg::MAX_TAPS) ? fcwd_pkg::MAX_TAPS : taps;
        if (!filter_on || n == 0) return x;
        // stale position after tap_count was lowered restarts at zero
        pos   = (wpos[ch] >= n) ? 0 : wpos[ch];
        g_wet = (wet > 32768) ? 32768 : wet;
        g_dry = (dry > 32768) ? 32768 : dry;
        hist[ch][pos] = x;
        acc = 0;
        for (j = 0; j < n; j++) begin
            idx = (pos >= j) ? pos - j : pos + n - j;
            acc += longint'(hist[ch][idx]) * longint'(coefs[j]);
        end
        total = longint'(g_dry) * longint'(x) * 64'sd32768 + longint'(g_wet) * acc;
        q = (total + (longint'(1) <<< 29)) >>> 30;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        pos++;
        if (pos >= n) pos = 0;
        wpos[ch] = pos;
        return q[fcwd_pkg::SAMPLE_W-1:0];
    endfunction

    function void note_input(logic [fcwd_pkg::OP_W-1:0] op,
                             logic [fcwd_pkg::IN_DATA_W-1:0] data);
        mix_result_t r;
        case (op)
            fcwd_pkg::OP_COEF:
                coefs[data[fcwd_pkg::IN_IDX_LSB +: fcwd_pkg::IDX_W]] =
                    data[fcwd_pkg::IN_COEF_LSB +: fcwd_pkg::COEF_W];
            fcwd_pkg::OP_CLEAR: begin
                foreach (hist[c, k]) hist[c][k] = '0;
                foreach (wpos[c]) wpos[c] = 0;
            end
            fcwd_pkg::OP_SAMPLE: begin
                r.ch  = data[fcwd_pkg::IN_CH_LSB];
                r.smp = mix_sample(data[fcwd_pkg::IN_SAMPLE_LSB +: fcwd_pkg::SAMPLE_W],
                                   r.ch % fcwd_pkg::CHANNELS);
                expected_mix.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function void check_output(logic [fcwd_pkg::OUT_DATA_W-1:0] data);
        mix_result_t e;
        logic signed [fcwd_pkg::SAMPLE_W-1:0] got_smp;
        logic                                 got_ch;
        got_smp = data[fcwd_pkg::SAMPLE_W-1:0];
        got_ch  = data[fcwd_pkg::SAMPLE_W];
        if (expected_mix.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output: sample %0d ch %0d", got_smp, got_ch);
            return;
        end
        e = expected_mix.pop_front();
        if (e.smp !== got_smp || e.ch !== got_ch) begin
            mismatches++;
            if (mismatches <= 10)
                $display("output mismatch: expected sample %0d ch %0d, got sample %0d ch %0d",
                         e.smp, e.ch, got_smp, got_ch);
        end
    endfunction

    function int pending();
        return expected_mix.size();
    endfunction
endclass

module tb_top;
    import fcwd_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
    localparam int              ITEM_TARGET   = 1400;
    localparam int              SETTLE_CYCLES = 600;
    localparam longint          CYCLE_LIMIT   = 2000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [OP_W-1:0]       s_axis_tuser;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_AW-1:0]     i_cfg_addr;
    logic [CFG_DW-1:0]     i_cfg_wdata;

    fir_mix_scoreboard sb;
    int                in_idle_pct;
    int                out_idle_pct;
    int                rx_hold;
    longint            cycle_count;

    fir_convolution_wet_dry uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // transaction monitor and watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
        end
        if (cycle_count == CYCLE_LIMIT) begin
            $display("fir_convolution_wet_dry test failed");
            $finish;
        end
    end

    // receiver: random back-pressure, plus a counted hold-off when requested
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold = rx_hold - 1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] pick_level();
        case ($urandom_range(5))
            0:       return '0;
            1:       return LEVEL_ONE;
            2:       return 16'hffff;
            3:       return CFG_DW'($urandom_range(65535));
            default: return CFG_DW'($urandom_range(32768));
        endcase
    endfunction

    function automatic int unsigned pick_taps();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 0;
        if (r < 60) return $urandom_range(16, 1);
        if (r < 80) return $urandom_range(64, 17);
        if (r < 92) return $urandom_range(255, 65);
        if (r < 96) return MAX_TAPS;
        return $urandom_range(511, 257);
    endfunction

    task automatic push_item(input logic [OP_W-1:0] op, input logic [15:0] smp,
                             input logic ch, input logic [7:0] idx, input logic [15:0] coef);
        logic [IN_DATA_W-1:0] data;
        data = '0;
        data[IN_SAMPLE_LSB +: SAMPLE_W] = smp;
        data[IN_CH_LSB]                 = ch;
        data[IN_IDX_LSB +: IDX_W]       = idx;
        data[IN_COEF_LSB +: COEF_W]     = coef;
        while ($urandom_range(99) < in_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // drop valid, drain expectations, then give a trailing clear sweep time to finish
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        sb.set_register(idx, value);
    endtask

    task automatic program_regs(input logic en, input logic [CFG_DW-1:0] taps,
                                input logic [CFG_DW-1:0] wet, input logic [CFG_DW-1:0] dry);
        settle();
        write_reg(CFG_ENABLED, CFG_DW'(en));
        write_reg(CFG_TAP_COUNT, taps);
        write_reg(CFG_WET_LEVEL, wet);
        write_reg(CFG_DRY_LEVEL, dry);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int          items_done;
        int          phase;
        int          len;
        int          k;
        int          r;
        int unsigned taps;
        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        in_idle_pct   = 24;
        out_idle_pct  = 24;
        rx_hold       = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset state is a bypass: samples pass straight through
        push_item(OP_SAMPLE, 16'h7fff, 1'b0, 8'h00, 16'h0000);
        push_item(OP_SAMPLE, 16'h8000, 1'b1, 8'hff, 16'hffff);
        push_item(OP_UNUSED, 16'h1234, 1'b0, 8'h00, 16'h0000);
        push_item(OP_COEF, 16'h0000, 1'b0, 8'd0, 16'h7fff);
        push_item(OP_COEF, 16'h0000, 1'b0, 8'd1, 16'h8000);
        push_item(OP_COEF, 16'h0000, 1'b0, 8'd2, 16'h4000);
        push_item(OP_COEF, 16'h0000, 1'b0, 8'd3, 16'hffff);
        push_item(OP_COEF, 16'h0000, 1'b0, 8'd255, 16'h3039);
        program_regs(1'b1, 16'd4, LEVEL_ONE, LEVEL_ONE);
        push_item(OP_SAMPLE, 16'h7fff, 1'b0, 8'h00, 16'h0000);
        push_item(OP_SAMPLE, 16'h7fff, 1'b1, 8'h00, 16'h0000);
        push_item(OP_SAMPLE, 16'h8000, 1'b0, 8'h00, 16'h0000);
        push_item(OP_SAMPLE, 16'h8000, 1'b1, 8'h00, 16'h0000);
        push_item(OP_SAMPLE, 16'h0000, 1'b0, 8'h00, 16'h0000);
        push_item(OP_SAMPLE, 16'h0001, 1'b1, 8'h00, 16'h0000);
        program_regs(1'b0, 16'd4, LEVEL_ONE, LEVEL_ONE);
        push_item(OP_SAMPLE, 16'h5555, 1'b0, 8'h00, 16'h0000);
        // both write positions now sit beyond the shorter tap count
        program_regs(1'b1, 16'd2, 16'hffff, 16'd40000);
        push_item(OP_SAMPLE, 16'h7fff, 1'b0, 8'h00, 16'h0000);
        push_item(OP_SAMPLE, 16'h8000, 1'b1, 8'h00, 16'h0000);
        push_item(OP_SAMPLE, 16'h7fff, 1'b0, 8'h00, 16'h0000);
        push_item(OP_CLEAR, 16'h0000, 1'b0, 8'h00, 16'h0000);
        push_item(OP_SAMPLE, 16'h2000, 1'b1, 8'h00, 16'h0000);

        // load every tap so any tap count reads written coefficients only
        items_done = 0;
        for (k = 0; k < MAX_TAPS; k++) begin
            push_item(OP_COEF, pick_word(), 1'($urandom_range(1)), 8'(k), pick_word());
            items_done++;
        end

        phase = 0;
        while (items_done < ITEM_TARGET) begin
            taps = pick_taps();
            program_regs(($urandom_range(9) != 0), CFG_DW'(taps), pick_level(), pick_level());
            len = (taps > 64) ? $urandom_range(16, 8) : $urandom_range(50, 20);
            if (phase == 3) begin
                rx_hold = 1500;
                len     = 60;
            end
            if (phase == 8) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            if (phase == 13) begin
                in_idle_pct  = 24;
                out_idle_pct = 24;
            end
            for (k = 0; k < len; k++) begin
                r = $urandom_range(99);
                if (r < 84 || r >= 98) begin
                    push_item(OP_SAMPLE, pick_word(), 1'($urandom_range(1)),
                              8'($urandom), 16'($urandom));
                    items_done++;
                end else if (r < 92) begin
                    push_item(OP_COEF, 16'($urandom), 1'($urandom_range(1)),
                              8'($urandom), pick_word());
                    items_done++;
                end else if (r < 95) begin
                    push_item(OP_CLEAR, 16'($urandom), 1'($urandom_range(1)),
                              8'($urandom), 16'($urandom));
                    items_done++;
                end else begin
                    push_item(OP_UNUSED, 16'($urandom), 1'($urandom_range(1)),
                              8'($urandom), 16'($urandom));
                end
            end
            phase++;
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("fir_convolution_wet_dry test passed");
        end else begin
            $display("fir_convolution_wet_dry test failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/fcwd_pkg.sv
hw/rtl/fcwd_ram.sv
hw/rtl/fcwd_ctrl.sv
hw/rtl/fcwd_datapath.sv
hw/rtl/fir_convolution_wet_dry.sv
sim/tb_top.sv
